// ===== rtl/cpa_pkg.sv =====
// Shared types and constants for the contiguous page allocator.
// No dependencies; used by cpa_cell, cpa_ctrl and the top level.
package cpa_pkg;

	localparam int NUM_PAGES  = 256;
	localparam int OWNER_BITS = 16;
	localparam int IDX_W      = $clog2(NUM_PAGES);
	localparam int CNT_W      = IDX_W + 1;
	localparam int VAL_W      = (OWNER_BITS > IDX_W) ? OWNER_BITS : IDX_W;
	// wide enough for page + count sums and all comparisons
	localparam int CMP_W      = ((CNT_W > 9) ? CNT_W : 9) + 1;

	typedef enum logic [1:0] {
		K_FREE,
		K_HEAD,
		K_TAIL
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [VAL_W-1:0]  val;
	} entry_t;

	typedef enum logic [2:0] {
		CMD_CLEAR,
		CMD_ALLOC,
		CMD_RESIZE,
		CMD_FREE,
		CMD_LARGEST,
		CMD_RMAP
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_NOROOM,
		ST_UNMAPPED,
		ST_BAD
	} status_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

// ===== rtl/contiguous_page_allocator.sv =====
// First-fit contiguous page allocator, top level.
// Depends on cpa_pkg, cpa_cell, cpa_ctrl.
//
// Usage:
//   Command channel: cmd_valid / cmd_stall with fields command, page, count,
//   old_count, new_count, owner_id. A beat is taken when cmd_valid is high
//   and cmd_stall is low. One command is in flight at a time; cmd_stall is
//   high from acceptance until the result has been moved to the result register.
//   Result channel: rsp_valid / rsp_stall with status, start_page,
//   found_owner, page_offset, largest_free. One result beat per command.
//   Command flow (accept to result): clear and commands rejected on their
//   fields go straight to the result, with no pass. Free, largest-run query,
//   reverse map of a head, and any command that fails in the first pass take
//   one pass. Successful allocate and resize, and reverse map of a tail, take
//   two passes. A pass rotates the page map once around the cell chain, one
//   entry per cycle past the controller.
//   Reset: all pages free, no result pending, ready for a command.
//   A stalled result holds; the next command may be taken meanwhile, and
//   its result waits in the controller until the result register frees.
module contiguous_page_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [2:0]  command,
	input  logic [7:0]  page,
	input  logic [8:0]  count,
	input  logic [8:0]  old_count,
	input  logic [8:0]  new_count,
	input  logic [15:0] owner_id,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [7:0]  start_page,
	output logic [15:0] found_owner,
	output logic [7:0]  page_offset,
	output logic [8:0]  largest_free
);
	import cpa_pkg::*;

	entry_t    ent [NUM_PAGES];
	entry_t    wb;
	cell_ctl_t ctl;

	// ring: cell k takes from cell k+1, the last cell takes the updated head
	for (genvar k = 0; k < NUM_PAGES; k++) begin : g_cell
		if (k == NUM_PAGES - 1) begin : g_last
			cpa_cell u_cell (.clk(clk), .arst_n(arst_n), .ctl(ctl), .d(wb), .q(ent[k]));
		end else begin : g_mid
			cpa_cell u_cell (.clk(clk), .arst_n(arst_n), .ctl(ctl), .d(ent[k+1]), .q(ent[k]));
		end
	end

	cpa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.command      (command),
		.page         (page),
		.count        (count),
		.old_count    (old_count),
		.new_count    (new_count),
		.owner_id     (owner_id),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.start_page   (start_page),
		.found_owner  (found_owner),
		.page_offset  (page_offset),
		.largest_free (largest_free),
		.head         (ent[0]),
		.wb           (wb),
		.ctl          (ctl)
	);

endmodule

// ===== rtl/cpa_cell.sv =====
// One page map entry in the rotating chain.
// Depends on cpa_pkg.
module cpa_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  cpa_pkg::cell_ctl_t ctl,
	input  cpa_pkg::entry_t   d,
	output cpa_pkg::entry_t   q
);
	import cpa_pkg::*;

	entry_t ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '{kind: K_FREE, val: '0};
		end else if (ctl.clear) begin
			ent_q <= '{kind: K_FREE, val: '0};
		end else if (ctl.shift) begin
			ent_q <= d;
		end
	end

	assign q = ent_q;

endmodule

// ===== rtl/cpa_ctrl.sv =====
// Command sequencer: watches the entry at the chain head, writes back the
// updated entry at the tail, and holds the result register.
// Depends on cpa_pkg.
module cpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [2:0]         command,
	input  logic [7:0]         page,
	input  logic [8:0]         count,
	input  logic [8:0]         old_count,
	input  logic [8:0]         new_count,
	input  logic [15:0]        owner_id,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         status,
	output logic [7:0]         start_page,
	output logic [15:0]        found_owner,
	output logic [7:0]         page_offset,
	output logic [8:0]         largest_free,
	input  cpa_pkg::entry_t    head,
	output cpa_pkg::entry_t    wb,
	output cpa_pkg::cell_ctl_t ctl
);
	import cpa_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_P1, S_P2, S_OUT} state_t;

	state_t                state_q;
	logic [IDX_W-1:0]      idx_q;
	logic [2:0]            cmd_q;
	logic [7:0]            pg_q;
	logic [8:0]            cnt_q, oldc_q, newc_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [CNT_W-1:0]      run_q, best_q;
	logic                  found_q, blocked_q, active_q;
	logic [IDX_W-1:0]      s_q, tgt_q;
	entry_t                rec_q;
	status_t               st_q;
	logic [7:0]            sp_q, po_q;
	logic [15:0]           fo_q;
	logic [8:0]            lf_q;
	logic                  rsp_valid_q;
	status_t               status_q;
	logic [7:0]            start_page_q, page_offset_q;
	logic [15:0]           found_owner_q;
	logic [8:0]            largest_free_q;

	logic              accept, last, at_ref, hit, blk, is_free;
	logic              load_rsp, p2_next, chk_done;
	status_t           chk_st;
	logic [CMP_W-1:0]  iw, pgw, off, offa, sw, cntw, oldw, neww, tgtw;
	logic [CNT_W-1:0]  run_d, best_d;
	entry_t            rec_now;

	assign accept  = cmd_valid && (state_q == S_IDLE);
	assign last    = (idx_q == IDX_W'(NUM_PAGES - 1));
	assign is_free = (head.kind == K_FREE);
	assign iw      = CMP_W'(idx_q);
	assign pgw     = CMP_W'(pg_q);
	assign sw      = CMP_W'(s_q);
	assign tgtw    = CMP_W'(tgt_q);
	assign cntw    = CMP_W'(cnt_q);
	assign oldw    = CMP_W'(oldc_q);
	assign neww    = CMP_W'(newc_q);
	assign off     = iw - pgw;
	assign offa    = iw - sw;
	assign at_ref  = (state_q == S_P1) ? (iw == pgw) : (iw == tgtw);
	assign rec_now = at_ref ? head : rec_q;
	assign run_d   = is_free ? run_q + 1'b1 : '0;
	assign best_d  = (run_d > best_q) ? run_d : best_q;
	assign hit     = is_free && !found_q && (CMP_W'(run_d) == cntw);
	assign blk     = (iw >= pgw) && (off >= oldw) && (off < neww) && !is_free;
	assign load_rsp = (state_q == S_OUT) && (!rsp_valid_q || !rsp_stall);

	assign ctl.shift = (state_q == S_P1) || (state_q == S_P2);
	assign ctl.clear = accept && (command == CMD_CLEAR);
	assign cmd_stall = (state_q != S_IDLE);

	// field checks that settle a command without a pass
	always_comb begin
		chk_st   = ST_OK;
		chk_done = 1'b0;
		unique case (command)
			CMD_CLEAR: chk_done = 1'b1;
			CMD_ALLOC: begin
				if (count == '0) begin
					chk_st   = ST_BAD;
					chk_done = 1'b1;
				end else if (CMP_W'(count) > CMP_W'(NUM_PAGES)) begin
					chk_st   = ST_NOROOM;
					chk_done = 1'b1;
				end
			end
			CMD_RESIZE: begin
				if (CMP_W'(page) >= CMP_W'(NUM_PAGES) ||
				    CMP_W'(page) + CMP_W'(old_count) > CMP_W'(NUM_PAGES) ||
				    CMP_W'(page) + CMP_W'(new_count) > CMP_W'(NUM_PAGES)) begin
					chk_st   = ST_BAD;
					chk_done = 1'b1;
				end
			end
			CMD_FREE, CMD_RMAP: begin
				if (CMP_W'(page) >= CMP_W'(NUM_PAGES)) begin
					chk_st   = ST_BAD;
					chk_done = 1'b1;
				end
			end
			CMD_LARGEST: chk_done = 1'b0;
			default: begin
				chk_st   = ST_BAD;
				chk_done = 1'b1;
			end
		endcase
	end

	// decides whether a second pass follows the first one
	always_comb begin
		p2_next = 1'b0;
		if (state_q == S_P1) begin
			unique case (cmd_q)
				CMD_ALLOC:  p2_next = found_q || hit;
				CMD_RESIZE: p2_next = (rec_now.kind == K_HEAD) &&
				                      ((newc_q <= oldc_q) || !(blocked_q || blk));
				CMD_RMAP:   p2_next = (rec_now.kind != K_FREE) && (rec_now.kind != K_HEAD) &&
				                      !(rec_now.val > VAL_W'(pg_q));
				default:    p2_next = 1'b0;
			endcase
		end
	end

	// write-back entry for the tail of the chain
	always_comb begin
		wb = head;
		if (cmd_q == CMD_ALLOC && state_q == S_P2) begin
			if (iw >= sw && offa < cntw) begin
				if (offa == '0) begin
					wb = '{kind: K_HEAD, val: VAL_W'(owner_q)};
				end else begin
					wb = '{kind: K_TAIL, val: VAL_W'(offa)};
				end
			end
		end else if (cmd_q == CMD_RESIZE && state_q == S_P2 && iw >= pgw) begin
			if (newc_q <= oldc_q) begin
				if (off >= neww && off < oldw) wb = '{kind: K_FREE, val: '0};
			end else if (off >= oldw && off < neww) begin
				wb = '{kind: K_TAIL, val: VAL_W'(off)};
			end
		end else if (cmd_q == CMD_FREE && state_q == S_P1) begin
			if ((iw == pgw && head.kind == K_HEAD) || (active_q && head.kind == K_TAIL)) begin
				wb = '{kind: K_FREE, val: '0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
			cmd_q       <= '0;
		end else begin
			if (load_rsp) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q     <= command;
						pg_q      <= page;
						cnt_q     <= count;
						oldc_q    <= old_count;
						newc_q    <= new_count;
						owner_q   <= OWNER_BITS'(owner_id);
						run_q     <= '0;
						best_q    <= '0;
						found_q   <= 1'b0;
						blocked_q <= 1'b0;
						active_q  <= 1'b0;
						st_q      <= chk_st;
						sp_q      <= '0;
						fo_q      <= '0;
						po_q      <= '0;
						lf_q      <= '0;
						state_q   <= chk_done ? S_OUT : S_P1;
					end
				end
				S_P1, S_P2: begin
					idx_q <= last ? '0 : idx_q + 1'b1;
					rec_q <= rec_now;
					run_q <= run_d;
					best_q <= best_d;
					if (hit) begin
						found_q <= 1'b1;
						s_q     <= IDX_W'(iw + 1'b1 - cntw);
					end
					if (state_q == S_P1 && blk) blocked_q <= 1'b1;
					if (iw == pgw && state_q == S_P1) active_q <= (head.kind == K_HEAD);
					else if (head.kind != K_TAIL) active_q <= 1'b0;
					if (last) begin
						state_q <= p2_next ? S_P2 : S_OUT;
						if (state_q == S_P1) begin
							unique case (cmd_q)
								CMD_ALLOC: begin
									if (!(found_q || hit)) st_q <= ST_NOROOM;
								end
								CMD_RESIZE: begin
									if (rec_now.kind == K_FREE) st_q <= ST_UNMAPPED;
									else if (rec_now.kind != K_HEAD) st_q <= ST_BAD;
									else if (newc_q > oldc_q && (blocked_q || blk))
										st_q <= ST_NOROOM;
								end
								CMD_FREE: begin
									if (rec_now.kind == K_FREE) st_q <= ST_UNMAPPED;
									else if (rec_now.kind != K_HEAD) st_q <= ST_BAD;
								end
								CMD_LARGEST: begin
									lf_q <= (CMP_W'(best_d) > CMP_W'(9'h1FF)) ?
									        9'h1FF : 9'(best_d);
								end
								CMD_RMAP: begin
									if (rec_now.kind == K_FREE) begin
										st_q <= ST_UNMAPPED;
									end else if (rec_now.kind == K_HEAD) begin
										fo_q <= 16'(rec_now.val);
									end else if (rec_now.val > VAL_W'(pg_q)) begin
										st_q <= ST_BAD;
									end else begin
										tgt_q <= IDX_W'(pgw - CMP_W'(rec_now.val));
										po_q  <= 8'(rec_now.val);
									end
								end
								default: st_q <= ST_BAD;
							endcase
						end else begin
							unique case (cmd_q)
								CMD_ALLOC:  sp_q <= 8'(s_q);
								CMD_RESIZE: sp_q <= pg_q;
								CMD_RMAP: begin
									if (rec_now.kind == K_HEAD) fo_q <= 16'(rec_now.val);
									else st_q <= ST_BAD;
								end
								default: st_q <= ST_BAD;
							endcase
						end
					end
				end
				S_OUT: begin
					if (load_rsp) begin
						status_q       <= st_q;
						start_page_q   <= (st_q == ST_OK) ? sp_q : '0;
						found_owner_q  <= (st_q == ST_OK) ? fo_q : '0;
						page_offset_q  <= (st_q == ST_OK) ? po_q : '0;
						largest_free_q <= (st_q == ST_OK) ? lf_q : '0;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign start_page   = start_page_q;
	assign found_owner  = found_owner_q;
	assign page_offset  = page_offset_q;
	assign largest_free = largest_free_q;

	// map is back in page order whenever a command can start
	a_aligned_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> idx_q == '0)
		else $error("chain not aligned at idle");

	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |-> !ctl.shift && state_q == S_IDLE)
		else $error("clear outside idle");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> start_page == '0 && found_owner == '0 &&
		page_offset == '0 && largest_free == '0)
		else $error("error beat carries data");

	a_p2_follows: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_P2) |-> $past(state_q) == S_P1 && $past(last))
		else $error("second pass not after a full first pass");

endmodule
